// File: hw/rtl/ffha_pkg.sv
package ffha_pkg;

  localparam int unsigned MAX_BLOCKS_D   = 64;
  localparam int unsigned HEADER_BYTES_D = 12;
  localparam int unsigned ALIGN_BYTES_D  = 4;

  localparam logic [1:0] CFG_REGION_START = 2'd0;
  localparam logic [1:0] CFG_REGION_BYTES = 2'd1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_GAP  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] request_bytes;
    logic [31:0] release_addr;
  } in_word_t;

  typedef struct packed {
    logic [31:0] block_addr;
    logic [1:0]  status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_WAIT,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS,
    S_HINT_RD,
    S_HINT_WAIT,
    S_HINT_CHK,
    S_DONE
  } ffha_state_t;

endpackage

// File: hw/rtl/first_fit_heap_allocator.sv
// First-fit heap allocator. One word in, one word out per request. The entry
// table lives in a single RAM (offset and used size per row, one read and one
// write port); a small sequencer walks it one row at a time.
// An allocate visits entries from the hint, moves entries up for the insertion
// and, when it filled the gap at the hint, walks the table again to advance
// the hint. A release searches entries and moves entries down. A config write
// resets the table by writing its two sentinel rows. The block takes no new
// word until its result is taken.
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_D,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_D,
  parameter int unsigned ALIGN_BYTES  = ALIGN_BYTES_D
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ffha_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ffha_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_wdata
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = AW + 1;
  localparam logic [33:0] AMASK = 34'(ALIGN_BYTES - 1);
  localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);

  ffha_state_t state_r, state_nxt;

  logic [31:0] rstart_r, rbytes_r;
  logic [31:0] base_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] hint_r, hint_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [AW-1:0] del_r, del_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [33:0]   need_r, need_nxt;
  logic [31:0]   lo_r, lo_nxt;
  logic [31:0]   cur_off_r, cur_off_nxt;
  logic [32:0]   cur_end_r, cur_end_nxt;
  logic          init_r;
  logic          found_r, found_nxt;
  logic          op_r;
  logic [31:0]   addr_r;
  logic [31:0]   res_addr_r, res_addr_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          phase_r, phase_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [63:0]   wdata, rdata;

  ffha_ram #(.WIDTH(64), .DEPTH(MAX_BLOCKS)) u_tab (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // region bounds from config registers
  logic [33:0] start34, end34, span34;
  logic        tiny;
  always_comb begin
    start34 = ({2'b0, rstart_r} + AMASK) & ~AMASK;
    end34   = ({2'b0, rstart_r} + {2'b0, rbytes_r}) & ~AMASK;
    tiny    = (end34 < start34 + 2 * HDR34) || (end34 - start34 > 34'hFFFF_FFFF);
    span34  = tiny ? 2 * HDR34 : end34 - start34;
  end

  // row fields from the RAM read data; sentinel rows 0 and 1 are written at init
  logic [31:0] rd_off, rd_used;
  assign rd_off  = rdata[63:32];
  assign rd_used = rdata[31:0];

  logic [32:0] gap_hi_end;
  assign gap_hi_end = {1'b0, rd_off};

  // config registers and init flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rstart_r <= '0;
      rbytes_r <= 32'd65536;
      init_r   <= 1'b1;
    end else if (cfg_we && (cfg_index == CFG_REGION_START || cfg_index == CFG_REGION_BYTES)) begin
      if (cfg_index == CFG_REGION_START) rstart_r <= cfg_wdata;
      else rbytes_r <= cfg_wdata;
      init_r <= 1'b1;
    end else if (state_r == S_INIT && phase_r) begin
      init_r <= 1'b0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (init_r) state_nxt = S_INIT;
        else if (in_valid) begin
          if (in_data.op == OP_ALLOC && count_r >= CW'(MAX_BLOCKS)) state_nxt = S_DONE;
          else state_nxt = S_RD;
        end
      end
      S_INIT:      if (phase_r) state_nxt = S_IDLE;
      S_RD:        state_nxt = S_WAIT;
      S_WAIT:      state_nxt = S_CHECK;
      S_CHECK: begin
        if (found_nxt) begin
          state_nxt = (op_r == OP_ALLOC) ? S_SHIFT_RD : S_SHIFT_RD;
        end else if (k_nxt >= count_r) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_SHIFT_RD:  state_nxt = (op_r == OP_ALLOC) ?
                     ((k_r < CW'(pos_r)) ? S_INS : S_SHIFT_WR) :
                     ((k_r >= count_r) ? S_DONE : S_SHIFT_WR);
      S_SHIFT_WR:  state_nxt = phase_r ? S_SHIFT_RD : S_SHIFT_WR;
      S_INS:       state_nxt = (idx_r == hint_r) ? S_HINT_RD : S_DONE;
      S_HINT_RD:   state_nxt = S_HINT_WAIT;
      S_HINT_WAIT: state_nxt = S_HINT_CHK;
      S_HINT_CHK:  state_nxt = found_nxt || (k_nxt >= count_r) ? S_DONE : S_HINT_RD;
      S_DONE:      if (out_ready) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // datapath and table writes
  always_comb begin
    count_nxt    = count_r;
    hint_nxt     = hint_r;
    idx_nxt      = idx_r;
    pos_nxt      = pos_r;
    del_nxt      = del_r;
    k_nxt        = k_r;
    need_nxt     = need_r;
    lo_nxt       = lo_r;
    cur_off_nxt  = cur_off_r;
    cur_end_nxt  = cur_end_r;
    found_nxt    = 1'b0;
    res_addr_nxt = res_addr_r;
    res_st_nxt   = res_st_r;
    phase_nxt    = 1'b0;
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = k_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        res_addr_nxt = '0;
        res_st_nxt   = ST_OK;
        need_nxt = ({2'b0, in_data.request_bytes} + HDR34 + AMASK) & ~AMASK;
        if (in_data.op == OP_ALLOC) begin
          k_nxt = CW'(hint_r);
          if (count_r >= CW'(MAX_BLOCKS)) res_st_nxt = ST_FULL;
        end else begin
          k_nxt = CW'(1);
        end
      end
      S_INIT: begin
        we        = 1'b1;
        phase_nxt = 1'b1;
        waddr     = phase_r ? AW'(1) : '0;
        wdata     = phase_r ? {span34[31:0] - 32'(HEADER_BYTES), 32'(HEADER_BYTES)}
                            : {32'd0, 32'(HEADER_BYTES)};
        count_nxt = CW'(2);
        hint_nxt  = '0;
      end
      S_RD: begin
        raddr = k_r[AW-1:0];
      end
      S_WAIT: begin
        // alloc reads row k+1 next to compare its start with the end of row k
        raddr = AW'(k_r + CW'(1));
        cur_off_nxt = rd_off;
        cur_end_nxt = {1'b0, rd_off} + {1'b0, rd_used};
      end
      S_CHECK: begin
        if (op_r == OP_ALLOC) begin
          // only a gap before a live row counts; the tail has none after it
          if (k_r + CW'(1) < count_r && gap_hi_end > cur_end_r &&
              ({1'b0, gap_hi_end} - {1'b0, cur_end_r}) >= need_r) begin
            found_nxt = 1'b1;
            idx_nxt   = k_r[AW-1:0];
            pos_nxt   = AW'(k_r + CW'(1));
            lo_nxt    = cur_end_r[31:0];
            k_nxt     = count_r - CW'(1);
          end else begin
            k_nxt = k_r + CW'(1);
            if (k_nxt + CW'(1) >= count_r) begin
              k_nxt = count_r;
              res_st_nxt = ST_NO_GAP;
            end
          end
        end else begin
          if (k_r + CW'(1) < count_r &&
              base_r + cur_off_r + 32'(HEADER_BYTES) == addr_r) begin
            found_nxt = 1'b1;
            del_nxt   = k_r[AW-1:0];
            k_nxt     = k_r + CW'(1);
          end else begin
            k_nxt = k_r + CW'(1);
            if (k_nxt + CW'(1) >= count_r) begin
              k_nxt = count_r;
              res_st_nxt = ST_UNKNOWN;
            end
          end
        end
      end
      S_SHIFT_RD: begin
        raddr = k_r[AW-1:0];
        if (op_r == OP_RELEASE && k_r >= count_r) begin
          count_nxt = count_r - CW'(1);
          if (hint_r >= del_r) hint_nxt = del_r - AW'(1);
        end
      end
      S_SHIFT_WR: begin
        // the first phase waits on read data, the second writes it
        phase_nxt = ~phase_r;
        if (phase_r) begin
          we = 1'b1;
          if (op_r == OP_ALLOC) begin
            waddr = AW'(k_r + CW'(1));
            k_nxt = k_r - CW'(1);
          end else begin
            waddr = AW'(k_r - CW'(1));
            k_nxt = k_r + CW'(1);
          end
          wdata = rdata;
        end
      end
      S_INS: begin
        we    = 1'b1;
        waddr = pos_r;
        wdata = {lo_r, need_r[31:0]};
        count_nxt    = count_r + CW'(1);
        res_addr_nxt = base_r + lo_r + 32'(HEADER_BYTES);
        k_nxt = CW'(hint_r);
      end
      S_HINT_RD: raddr = k_r[AW-1:0];
      S_HINT_WAIT: begin
        raddr = AW'(k_r + CW'(1));
        cur_end_nxt = {1'b0, rd_off} + {1'b0, rd_used};
      end
      S_HINT_CHK: begin
        if (gap_hi_end > cur_end_r && (gap_hi_end - cur_end_r) > 33'(HEADER_BYTES)) begin
          found_nxt = 1'b1;
          hint_nxt  = k_r[AW-1:0];
        end else begin
          k_nxt = k_r + CW'(1);
          if (k_nxt + CW'(1) >= count_r) begin
            k_nxt = count_r;
            hint_nxt = AW'(count_r - CW'(1));
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CW'(2);
      hint_r  <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      hint_r  <= hint_nxt;
      phase_r <= phase_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    del_r      <= del_nxt;
    k_r        <= k_nxt;
    need_r     <= need_nxt;
    lo_r       <= lo_nxt;
    cur_off_r  <= cur_off_nxt;
    cur_end_r  <= cur_end_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    found_r    <= found_nxt;
    if (state_r == S_INIT) begin
      base_r <= start34[31:0];
    end
    if (state_r == S_IDLE && in_valid) begin
      op_r   <= in_data.op;
      addr_r <= in_data.release_addr;
    end
  end

  // outputs
  always_comb begin
    in_ready            = (state_r == S_IDLE) && !init_r;
    out_valid           = (state_r == S_DONE);
    out_data.block_addr = (res_st_r == ST_OK && op_r == OP_ALLOC && !(found_r && 1'b0))
                          ? res_addr_r : '0;
    out_data.status     = res_st_r;
  end
endmodule

// File: hw/rtl/ffha_ram.sv
module ffha_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
